[design/bdlp_pkg.sv]
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants of the button debounce / long press block
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

   // number of qualified buttons (1 to 8)
   localparam int Buttons = 6;
   // width of the level field and of the result masks
   localparam int LevelBits = 6;
   localparam int IndexBits = 3;
   localparam int TimeBits = 32;
   localparam int CfgBits = 16;
   localparam int AddrBits = 3;
   localparam int DataBits = 32;

   // register indexes (address bit 2)
   localparam logic RegDebounce = 1'b0;
   localparam logic RegLongPress = 1'b1;

   localparam logic [CfgBits-1:0] DebounceReset = 16'd50;
   localparam logic [CfgBits-1:0] LongPressReset = 16'd1000;

   // request function codes
   localparam logic FuncTick = 1'b0;
   localparam logic FuncTake = 1'b1;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'b001,
      MODE_PRESSED = 3'b010,
      MODE_HOLD    = 3'b100
   } mode_type;

   typedef struct packed {
      logic                 func;
      logic [TimeBits-1:0]  now_ms;
      logic [LevelBits-1:0] button_levels;
      logic [IndexBits-1:0] button_index;
   } req_type;

   typedef struct packed {
      logic                 took_press;
      logic [LevelBits-1:0] pressed_mask;
      logic [LevelBits-1:0] hold_mask;
   } rsp_type;

   // per-button control from the top level
   typedef struct packed {
      logic upd;
      logic is_take;
      logic take_sel;
      logic level;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[design/bdlp_btn_cell.sv]
// ----------------------------------------------------------------------------
// bdlp_btn_cell
// state and next-state logic of one button: level, press stamp and mode
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_btn_cell
   import bdlp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [TimeBits-1:0] now_ms,
   input  wire logic [CfgBits-1:0]  debounce_time,
   input  wire logic [CfgBits-1:0]  long_press_time,
   output mode_type                 mode_next,
   output logic                     take_hit
);

   logic                last_level_ff, last_level_in;
   logic [TimeBits-1:0] press_stamp_ff, press_stamp_in;
   mode_type            mode_ff, mode_in;
   logic [TimeBits-1:0] elapsed;
   logic                rise;

   // wrapping time since the last accepted press
   assign elapsed  = now_ms - press_stamp_ff;
   assign rise     = ctrl.level & ~last_level_ff;
   assign take_hit = ctrl.is_take & ctrl.take_sel & (mode_ff == MODE_PRESSED);

   always_comb begin
      last_level_in  = last_level_ff;
      press_stamp_in = press_stamp_ff;
      mode_in        = mode_ff;
      if (ctrl.upd) begin
         if (ctrl.is_take) begin
            if (take_hit) begin
               mode_in = MODE_HOLD;
            end
         end else begin
            if (rise) begin
               if (elapsed > TimeBits'(debounce_time)) begin
                  press_stamp_in = now_ms;
                  mode_in        = MODE_PRESSED;
               end
            end else if (ctrl.level && (elapsed > TimeBits'(long_press_time)) &&
                         (mode_ff == MODE_PRESSED)) begin
               mode_in = MODE_HOLD;
            end else if (!ctrl.level) begin
               mode_in = MODE_IDLE;
            end
            last_level_in = ctrl.level;
         end
      end
   end

   assign mode_next = mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff  <= 1'b0;
         press_stamp_ff <= '0;
         mode_ff        <= MODE_IDLE;
      end else begin
         last_level_ff  <= last_level_in;
         press_stamp_ff <= press_stamp_in;
         mode_ff        <= mode_in;
      end
   end

endmodule

`default_nettype wire

[design/bdlp_csr.sv]
// ----------------------------------------------------------------------------
// bdlp_csr
// apb-style register file for the debounce and long press times
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_csr
   import bdlp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [AddrBits-1:0] paddr,
   input  wire logic [DataBits-1:0] pwdata,
   output logic [DataBits-1:0]      prdata,
   output logic                     pready,
   output logic [CfgBits-1:0]       debounce_time,
   output logic [CfgBits-1:0]       long_press_time
);

   logic [CfgBits-1:0] debounce_ff, debounce_in;
   logic [CfgBits-1:0] long_press_ff, long_press_in;
   logic               wr_en;
   logic               reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      if (wr_en) begin
         case (reg_sel)
            RegDebounce:  debounce_in   = pwdata[CfgBits-1:0];
            RegLongPress: long_press_in = pwdata[CfgBits-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         RegDebounce:  prdata = DataBits'(debounce_ff);
         RegLongPress: prdata = DataBits'(long_press_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DebounceReset;
         long_press_ff <= LongPressReset;
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
      end
   end

   assign debounce_time   = debounce_ff;
   assign long_press_time = long_press_ff;

endmodule

`default_nettype wire

[design/button_debounce_long_press_top.sv]
// ----------------------------------------------------------------------------
// button_debounce_long_press_top
// qualifies a bank of push buttons into idle, pressed and hold states
// ----------------------------------------------------------------------------
// usage
//  - req channel (valid/ready): a tick transfer carries now_ms and the button
//    levels; a take transfer consumes a pending press on button_index
//  - rsp channel (valid/ready): one transfer per request, with took_press
//    and the pressed and hold masks after the request has been applied
//  - apb-style port: debounce_time at address 0, long_press_time at 4;
//    write only while the block is idle
//  - a request lands in the input register; once the result register is free
//    or being emptied, it updates the button state and loads the result
//    register, whose valid flag drives rsp_valid
//  - throughput: one request per cycle unless rsp stalls; each button's
//    update is one 32-bit subtract and two compares, all buttons in parallel
//  - a stalled rsp side holds the result register; the input register
//    still takes one more request, then req_ready drops until rsp_ready
//  - reset clears all button state to idle with zero stamps and loads the
//    default times (50 ms debounce, 1000 ms long press)
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press_top
   import bdlp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_data,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data,
   // configuration port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [AddrBits-1:0] paddr,
   input  wire logic [DataBits-1:0] pwdata,
   output logic [DataBits-1:0]      prdata,
   output logic                     pready
);

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic               advance;
   logic [CfgBits-1:0] debounce_time;
   logic [CfgBits-1:0] long_press_time;

   logic [Buttons-1:0]   pressed_vec;
   logic [Buttons-1:0]   hold_vec;
   logic [Buttons-1:0]   hit_vec;
   logic [LevelBits-1:0] pressed_mask;
   logic [LevelBits-1:0] hold_mask;

   bdlp_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .debounce_time   (debounce_time),
      .long_press_time (long_press_time)
   );

   // item in the input register moves on when the result register is free
   // or is being emptied this cycle
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   // one cell per button, all updated in the same cycle
   for (genvar i = 0; i < Buttons; i++) begin : g_btn
      cell_ctrl_type ctrl;
      mode_type      mode_next;
      logic          level;

      if (i < LevelBits) begin : g_lvl
         assign level = in_data_ff.button_levels[i];
      end else begin : g_nolvl
         // buttons beyond the level field read as released
         assign level = 1'b0;
      end

      assign ctrl.upd      = advance;
      assign ctrl.is_take  = (in_data_ff.func == FuncTake);
      assign ctrl.take_sel = (32'(in_data_ff.button_index) == i);
      assign ctrl.level    = level;

      bdlp_btn_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (ctrl),
         .now_ms          (in_data_ff.now_ms),
         .debounce_time   (debounce_time),
         .long_press_time (long_press_time),
         .mode_next       (mode_next),
         .take_hit        (hit_vec[i])
      );

      assign pressed_vec[i] = (mode_next == MODE_PRESSED);
      assign hold_vec[i]    = (mode_next == MODE_HOLD);
   end

   // masks cover only the buttons that have a level bit
   for (genvar j = 0; j < LevelBits; j++) begin : g_mask
      if (j < Buttons) begin : g_on
         assign pressed_mask[j] = pressed_vec[j];
         assign hold_mask[j]    = hold_vec[j];
      end else begin : g_off
         assign pressed_mask[j] = 1'b0;
         assign hold_mask[j]    = 1'b0;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_data_in = req_data;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in             = 1'b1;
         // take hit only fires for an in-range button
         out_data_in.took_press   = |hit_vec;
         out_data_in.pressed_mask = pressed_mask;
         out_data_in.hold_mask    = hold_mask;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
